// ----- hdl/pldc_pkg.sv -----
// Shared types, widths and register indexes of the deadband-compensated PID loop.
`default_nettype none
package pldc_pkg;

	// Fixed-point scaling of the gains
	localparam int GAIN_FRAC_BITS = 8;

	// Field and state widths
	localparam int GAIN_W    = 16;
	localparam int RATE_W    = 16;
	localparam int LIMIT_W   = 15;
	localparam int ILIMIT_W  = 23;
	localparam int DRIVE_W   = 16;
	localparam int ERR_W     = RATE_W + 1;
	localparam int DERR_W    = ERR_W + 1;
	localparam int INTEG_W   = ILIMIT_W + 1;

	// Product and sum widths (gains are taken as signed with a zero sign bit)
	localparam int PROD_P_W  = GAIN_W + ERR_W;
	localparam int PROD_I_W  = GAIN_W + INTEG_W;
	localparam int PROD_D_W  = GAIN_W + DERR_W;
	localparam int SUM_W     = PROD_I_W + 2;
	localparam int RAW_W     = SUM_W - GAIN_FRAC_BITS;
	localparam int COMP_W    = RAW_W + 1;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = ILIMIT_W;

	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P          = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I          = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D          = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMIT    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DEADZONE_OFFSET = 3'd5;

	// Register file contents
	typedef struct packed {
		logic [GAIN_W-1:0]   gain_p;
		logic [GAIN_W-1:0]   gain_i;
		logic [GAIN_W-1:0]   gain_d;
		logic [LIMIT_W-1:0]  output_limit;
		logic [ILIMIT_W-1:0] integral_limit;
		logic [LIMIT_W-1:0]  deadzone_offset;
	} pldc_cfg_t;

	// Per-word terms handed from the state unit to the control law
	typedef struct packed {
		logic signed [ERR_W-1:0]   err;
		logic signed [DERR_W-1:0]  derr;
		logic signed [INTEG_W-1:0] integ;
	} pldc_terms_t;

endpackage
`default_nettype wire

// ----- hdl/pldc_cfg.sv -----
// Configuration register file of the PID loop.
`default_nettype none
module pldc_cfg (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [pldc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [pldc_pkg::CFG_DATA_W-1:0] cfg_data,
	output pldc_pkg::pldc_cfg_t                 cfg
);
	import pldc_pkg::*;

	pldc_cfg_t regs_q;

	// Writes are always taken
	assign cfg_ready = 1'b1;

	// Register write decode; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_GAIN_P:          regs_q.gain_p          <= cfg_data[GAIN_W-1:0];
				REG_GAIN_I:          regs_q.gain_i          <= cfg_data[GAIN_W-1:0];
				REG_GAIN_D:          regs_q.gain_d          <= cfg_data[GAIN_W-1:0];
				REG_OUTPUT_LIMIT:    regs_q.output_limit    <= cfg_data[LIMIT_W-1:0];
				REG_INTEGRAL_LIMIT:  regs_q.integral_limit  <= cfg_data[ILIMIT_W-1:0];
				REG_DEADZONE_OFFSET: regs_q.deadzone_offset <= cfg_data[LIMIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = regs_q;

endmodule
`default_nettype wire

// ----- hdl/pldc_state.sv -----
// Error, error difference and clamped integral, with the loop's state registers.
`default_nettype none
module pldc_state (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic signed [pldc_pkg::RATE_W-1:0] target_rate,
	input  wire logic signed [pldc_pkg::RATE_W-1:0] measured_rate,
	input  wire logic [pldc_pkg::GAIN_W-1:0]        gain_i,
	input  wire logic [pldc_pkg::ILIMIT_W-1:0]      integral_limit,
	input  wire logic                              update,
	output pldc_pkg::pldc_terms_t                  terms
);
	import pldc_pkg::*;

	logic signed [ERR_W-1:0]   prev_error_q;
	logic signed [INTEG_W-1:0] integral_q;

	logic signed [ERR_W-1:0]   err;
	logic signed [DERR_W-1:0]  derr;
	logic signed [INTEG_W:0]   integ_sum;
	logic signed [INTEG_W:0]   ilim;
	logic signed [INTEG_W-1:0] integ_next;

	// Error and its change since the last word
	assign err  = ERR_W'(target_rate) - ERR_W'(measured_rate);
	assign derr = DERR_W'(err) - DERR_W'(prev_error_q);

	// Accumulate and clamp; a zero integral gain clears the sum
	assign integ_sum = (INTEG_W+1)'(integral_q) + (INTEG_W+1)'(err);
	assign ilim      = $signed({2'b00, integral_limit});

	always_comb begin
		if (gain_i == '0) begin
			integ_next = '0;
		end else if (integ_sum > ilim) begin
			integ_next = ilim[INTEG_W-1:0];
		end else if (integ_sum < -ilim) begin
			integ_next = INTEG_W'(-ilim);
		end else begin
			integ_next = integ_sum[INTEG_W-1:0];
		end
	end

	// State advances once per word leaving the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_error_q <= '0;
			integral_q   <= '0;
		end else if (update) begin
			prev_error_q <= err;
			integral_q   <= integ_next;
		end
	end

	assign terms.err   = err;
	assign terms.derr  = derr;
	assign terms.integ = integ_next;

endmodule
`default_nettype wire

// ----- hdl/pldc_law.sv -----
// PID products, Q8.8 scaling, deadband compensation and output saturation.
`default_nettype none
module pldc_law (
	input  wire pldc_pkg::pldc_cfg_t               cfg,
	input  wire pldc_pkg::pldc_terms_t             terms,
	output logic signed [pldc_pkg::DRIVE_W-1:0]    drive
);
	import pldc_pkg::*;

	logic signed [PROD_P_W-1:0] prod_p;
	logic signed [PROD_I_W-1:0] prod_i;
	logic signed [PROD_D_W-1:0] prod_d;
	logic signed [SUM_W-1:0]    sum;
	logic signed [RAW_W-1:0]    raw;
	logic signed [COMP_W-1:0]   comp;
	logic signed [COMP_W-1:0]   offset;
	logic signed [COMP_W-1:0]   olim;
	logic signed [COMP_W-1:0]   sat;

	// Three gains, unsigned, against signed terms
	assign prod_p = PROD_P_W'($signed({1'b0, cfg.gain_p})) * PROD_P_W'(terms.err);
	assign prod_i = PROD_I_W'($signed({1'b0, cfg.gain_i})) * PROD_I_W'(terms.integ);
	assign prod_d = PROD_D_W'($signed({1'b0, cfg.gain_d})) * PROD_D_W'(terms.derr);

	assign sum = SUM_W'(prod_p) + SUM_W'(prod_i) + SUM_W'(prod_d);

	// Dropping the fraction bits floors toward minus infinity
	assign raw = sum[SUM_W-1:GAIN_FRAC_BITS];

	assign offset = COMP_W'($signed({1'b0, cfg.deadzone_offset}));
	assign olim   = COMP_W'($signed({1'b0, cfg.output_limit}));

	// Push nonzero drive away from zero, then saturate
	always_comb begin
		if (raw > 0) begin
			comp = COMP_W'(raw) + offset;
		end else if (raw < 0) begin
			comp = COMP_W'(raw) - offset;
		end else begin
			comp = '0;
		end
		if (comp > olim) begin
			sat = olim;
		end else if (comp < -olim) begin
			sat = -olim;
		end else begin
			sat = comp;
		end
	end

	assign drive = sat[DRIVE_W-1:0];

endmodule
`default_nettype wire

// ----- hdl/pid_loop_deadzone_compensated.sv -----
// Top level: positional PID loop with deadband compensation.
// Throughput: one word per cycle while out_stall does not hold the output register;
// each accepted input word is registered in the input stage, which feeds one pass of
// error, integral, three multiplies, sum and saturation into the output register.
// Reset (arst_n low, asynchronous): gains, limits, error and integral state clear
// to zero and both stages empty.
`default_nettype none
module pid_loop_deadzone_compensated (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic signed [pldc_pkg::RATE_W-1:0] target_rate,
	input  wire logic signed [pldc_pkg::RATE_W-1:0] measured_rate,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic signed [pldc_pkg::DRIVE_W-1:0]   drive,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [pldc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [pldc_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import pldc_pkg::*;

	pldc_cfg_t   cfg;
	pldc_terms_t terms;

	logic                       valid_s1;
	logic signed [RATE_W-1:0]   target_s1;
	logic signed [RATE_W-1:0]   measured_s1;
	logic                       out_valid_s2;
	logic signed [DRIVE_W-1:0]  drive_s2;
	logic signed [DRIVE_W-1:0]  drive_next;
	logic                       advance;
	logic                       move;

	// Output register frees up when empty or when its word is taken
	assign advance  = !out_valid_s2 || !out_stall;
	assign move     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	pldc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pldc_state u_state (
		.clk            (clk),
		.arst_n         (arst_n),
		.target_rate    (target_s1),
		.measured_rate  (measured_s1),
		.gain_i         (cfg.gain_i),
		.integral_limit (cfg.integral_limit),
		.update         (move),
		.terms          (terms)
	);

	pldc_law u_law (
		.cfg   (cfg),
		.terms (terms),
		.drive (drive_next)
	);

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			target_s1   <= target_rate;
			measured_s1 <= measured_rate;
		end
	end

	// Output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			drive_s2 <= drive_next;
		end
	end

	assign out_valid = out_valid_s2;
	assign drive     = drive_s2;

	// A held input word is never dropped
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && in_stall) |=> valid_s1)
		else $error("input stage word lost while stalled");

	// Stall only with a word in the input stage
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty input stage");

	// Zero integral gain leaves the integral cleared after a word
	a_integ_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(move && cfg.gain_i == '0) |=> (u_state.integral_q == '0))
		else $error("integral not cleared with zero integral gain");

	// Saturation never yields the most negative code
	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 |-> (drive_s2 != $signed({1'b1, {(DRIVE_W-1){1'b0}}})))
		else $error("drive outside symmetric range");

endmodule
`default_nettype wire

// ----- verif/pid_loop_deadzone_compensated_tb.sv -----
// Self-checking testbench of the deadband-compensated PID loop.
`timescale 1ns / 1ps

module pid_loop_deadzone_compensated_tb;
	import pldc_pkg::*;

	localparam int PHASES          = 8;
	localparam int WORDS_PER_PHASE = 125;
	localparam int SETTLE_CYCLES   = 8;
	localparam int HOLD_CYCLES     = 300;
	localparam int TIMEOUT_NS      = 5_000_000;
	localparam int DIR_ROWS        = 42;

	// Indexes that decode to no register
	localparam logic [CFG_IDX_W-1:0] REG_NONE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_NONE_HI = 3'd7;

	typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

	// One row of the directed table: a register write or a rate word
	typedef struct packed {
		row_kind_t                   kind;
		logic [CFG_IDX_W-1:0]        idx;
		logic [CFG_DATA_W-1:0]       data;
		logic signed [RATE_W-1:0]    tgt;
		logic signed [RATE_W-1:0]    meas;
		logic                        fixed_want;
		logic signed [DRIVE_W-1:0]   want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [RATE_W-1:0] target_rate = '0;
	logic signed [RATE_W-1:0] measured_rate = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [DRIVE_W-1:0] drive;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Predictor copy of the registers and loop state
	logic [GAIN_W-1:0]          kp = '0;
	logic [GAIN_W-1:0]          ki = '0;
	logic [GAIN_W-1:0]          kd = '0;
	logic [LIMIT_W-1:0]         out_lim = '0;
	logic [ILIMIT_W-1:0]        integ_lim = '0;
	logic [LIMIT_W-1:0]         dz_off = '0;
	logic signed [ERR_W-1:0]    err_prev = '0;
	logic signed [INTEG_W-1:0]  integ_acc = '0;

	logic signed [DRIVE_W-1:0] drive_expected [$];
	int mismatch_count = 0;

	// Idle percentages and long hold-off request for the output side
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_asked = 0;
	int hold_seen = 0;
	int hold_left = 0;

	// Note: 16'h8000 is the most negative rate
	stim_row_t dir_rows [DIR_ROWS] = '{
		'{ROW_WORD, '0, '0, 16'sd32767, 16'h8000, 1'b1, 16'sd0},
		'{ROW_WORD, '0, '0, 16'h8000, 16'sd32767, 1'b1, 16'sd0},
		'{ROW_CFG, REG_OUTPUT_LIMIT, 23'd32767, '0, '0, 1'b0, '0},
		'{ROW_CFG, REG_GAIN_P, 23'h7FFFFF, '0, '0, 1'b0, '0},
		'{ROW_WORD, '0, '0, 16'sd32767, 16'h8000, 1'b1, 16'sd32767},
		'{ROW_WORD, '0, '0, 16'h8000, 16'sd32767, 1'b1, -16'sd32767},
		'{ROW_WORD, '0, '0, 16'sd0, 16'sd0, 1'b1, 16'sd0},
		'{ROW_CFG, REG_NONE_LO, 23'h000123, '0, '0, 1'b0, '0},
		'{ROW_CFG, REG_NONE_HI, 23'h7FFFFF, '0, '0, 1'b0, '0},
		'{ROW_WORD, '0, '0, 16'sd100, 16'sd0, 1'b0, '0},
		'{ROW_CFG, REG_GAIN_P, 23'd1, '0, '0, 1'b0, '0},
		'{ROW_CFG, REG_DEADZONE_OFFSET, 23'd100, '0, '0, 1'b0, '0},
		'{ROW_WORD, '0, '0, 16'sd1, 16'sd0, 1'b1, 16'sd0},
		'{ROW_WORD, '0, '0, -16'sd1, 16'sd0, 1'b1, -16'sd101},
		'{ROW_WORD, '0, '0, 16'sd0, -16'sd256, 1'b1, 16'sd101},
		'{ROW_WORD, '0, '0, -16'sd255, 16'sd0, 1'b1, -16'sd101},
		'{ROW_CFG, REG_DEADZONE_OFFSET, 23'd32767, '0, '0, 1'b0, '0},
		'{ROW_WORD, '0, '0, 16'sd512, 16'sd0, 1'b1, 16'sd32767},
		'{ROW_CFG, REG_OUTPUT_LIMIT, 23'd0, '0, '0, 1'b0, '0},
		'{ROW_WORD, '0, '0, 16'sd512, 16'sd0, 1'b1, 16'sd0},
		'{ROW_CFG, REG_OUTPUT_LIMIT, 23'd20000, '0, '0, 1'b0, '0},
		'{ROW_CFG, REG_GAIN_P, 23'd0, '0, '0, 1'b0, '0},
		'{ROW_CFG, REG_DEADZONE_OFFSET, 23'd0, '0, '0, 1'b0, '0},
		'{ROW_CFG, REG_GAIN_I, 23'd256, '0, '0, 1'b0, '0},
		'{ROW_WORD, '0, '0, 16'sd30000, -16'sd30000, 1'b1, 16'sd0},
		'{ROW_CFG, REG_INTEGRAL_LIMIT, 23'h7FFFFF, '0, '0, 1'b0, '0},
		'{ROW_CFG, REG_GAIN_I, 23'hFFFF, '0, '0, 1'b0, '0},
		'{ROW_CFG, REG_GAIN_D, 23'hFFFF, '0, '0, 1'b0, '0},
		'{ROW_WORD, '0, '0, 16'sd32767, 16'h8000, 1'b0, '0},
		'{ROW_WORD, '0, '0, 16'sd32767, 16'h8000, 1'b0, '0},
		'{ROW_WORD, '0, '0, 16'h8000, 16'sd32767, 1'b0, '0},
		'{ROW_CFG, REG_GAIN_I, 23'd0, '0, '0, 1'b0, '0},
		'{ROW_WORD, '0, '0, 16'sd1000, 16'sd0, 1'b0, '0},
		'{ROW_CFG, REG_GAIN_P, 23'd300, '0, '0, 1'b0, '0},
		'{ROW_CFG, REG_GAIN_I, 23'd20, '0, '0, 1'b0, '0},
		'{ROW_CFG, REG_GAIN_D, 23'd40, '0, '0, 1'b0, '0},
		'{ROW_CFG, REG_INTEGRAL_LIMIT, 23'd5000, '0, '0, 1'b0, '0},
		'{ROW_CFG, REG_DEADZONE_OFFSET, 23'd50, '0, '0, 1'b0, '0},
		'{ROW_WORD, '0, '0, 16'sd1200, 16'sd1000, 1'b0, '0},
		'{ROW_WORD, '0, '0, 16'sd1200, 16'sd1150, 1'b0, '0},
		'{ROW_WORD, '0, '0, -16'sd700, -16'sd650, 1'b0, '0},
		'{ROW_WORD, '0, '0, 16'sd0, 16'sd40, 1'b0, '0}
	};

	pid_loop_deadzone_compensated u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.target_rate  (target_rate),
		.measured_rate(measured_rate),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.drive        (drive),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	// One PID step: integral update, Q8.8 sum with floor shift, deadband, clamp
	function automatic logic signed [DRIVE_W-1:0] pid_next_drive(
		input logic signed [RATE_W-1:0] tgt,
		input logic signed [RATE_W-1:0] meas
	);
		longint e;
		longint acc;
		longint prod_sum;
		longint raw;
		e = longint'(tgt) - longint'(meas);
		if (ki != '0) begin
			acc = longint'(integ_acc) + e;
			if (acc > longint'(integ_lim))
				acc = longint'(integ_lim);
			else if (acc < -longint'(integ_lim))
				acc = -longint'(integ_lim);
			integ_acc = acc[INTEG_W-1:0];
		end else begin
			integ_acc = '0;
		end
		prod_sum = longint'(kp) * e + longint'(ki) * longint'(integ_acc)
			+ longint'(kd) * (e - longint'(err_prev));
		raw = prod_sum >>> GAIN_FRAC_BITS;
		if (raw > 0)
			raw = raw + longint'(dz_off);
		else if (raw < 0)
			raw = raw - longint'(dz_off);
		if (raw > longint'(out_lim))
			raw = longint'(out_lim);
		else if (raw < -longint'(out_lim))
			raw = -longint'(out_lim);
		err_prev = e[ERR_W-1:0];
		return raw[DRIVE_W-1:0];
	endfunction

	task automatic report_mismatch(input string what);
		$display("%0t mismatch: %s", $time, what);
		mismatch_count++;
	endtask

	// Offer one rate word, hold it until accepted, then log its expected drive
	task automatic send_word(
		input logic signed [RATE_W-1:0] tgt,
		input logic signed [RATE_W-1:0] meas,
		input logic fixed_want,
		input logic signed [DRIVE_W-1:0] want
	);
		logic signed [DRIVE_W-1:0] pred;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		target_rate <= tgt;
		measured_rate <= meas;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pred = pid_next_drive(tgt, meas);
		drive_expected.push_back(fixed_want ? want : pred);
	endtask

	// Stop offering and wait until every drive word is back
	task automatic settle();
		in_valid <= 1'b0;
		while (drive_expected.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register write; the predictor keeps only the register's own width
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_GAIN_P:          kp = data[GAIN_W-1:0];
			REG_GAIN_I:          ki = data[GAIN_W-1:0];
			REG_GAIN_D:          kd = data[GAIN_W-1:0];
			REG_OUTPUT_LIMIT:    out_lim = data[LIMIT_W-1:0];
			REG_INTEGRAL_LIMIT:  integ_lim = data[ILIMIT_W-1:0];
			REG_DEADZONE_OFFSET: dz_off = data[LIMIT_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Output side: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_seen != hold_asked) begin
			hold_seen = hold_asked;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	// Compare each accepted drive word with the oldest expectation
	always @(posedge clk) begin : check_drive
		logic signed [DRIVE_W-1:0] want;
		if (arst_n && out_valid && !out_stall) begin
			if (drive_expected.size() == 0) begin
				report_mismatch($sformatf("drive %0d with no word pending", drive));
			end else begin
				want = drive_expected.pop_front();
				if (drive !== want)
					report_mismatch($sformatf("drive %0d, expected %0d", drive, want));
			end
		end
	end

	// Stimulus: directed table, then random phases
	initial begin : stimulus
		logic [GAIN_W-1:0] g_p;
		logic [GAIN_W-1:0] g_i;
		logic [GAIN_W-1:0] g_d;
		logic [LIMIT_W-1:0] o_l;
		logic [LIMIT_W-1:0] d_z;
		logic [ILIMIT_W-1:0] i_l;
		int t;
		int m;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[r]) begin
			if (dir_rows[r].kind == ROW_CFG) begin
				settle();
				write_reg(dir_rows[r].idx, dir_rows[r].data);
			end else begin
				send_word(dir_rows[r].tgt, dir_rows[r].meas, dir_rows[r].fixed_want,
					dir_rows[r].want);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			case (ph)
				0: begin
					// all registers at their top values
					g_p = '1; g_i = '1; g_d = '1;
					o_l = '1; i_l = '1; d_z = '1;
				end
				1: begin
					// proportional only, no deadband, integral held at zero
					g_p = 16'($urandom_range(1, 400)); g_i = '0; g_d = '0;
					o_l = '1; i_l = '0; d_z = '0;
				end
				default: begin
					g_p = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 600));
					g_d = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 600));
					g_i = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom_range(1, 300));
					o_l = ($urandom_range(0, 3) == 0) ? 15'h7FFF : 15'($urandom);
					i_l = ($urandom_range(0, 3) == 0) ? 23'($urandom) : 23'($urandom_range(0, 20000));
					d_z = ($urandom_range(0, 3) == 0) ? 15'($urandom) : 15'($urandom_range(0, 200));
				end
			endcase
			// junk above each register's width must be dropped
			write_reg(REG_GAIN_P, {7'($urandom), g_p});
			write_reg(REG_GAIN_I, {7'($urandom), g_i});
			write_reg(REG_GAIN_D, {7'($urandom), g_d});
			write_reg(REG_OUTPUT_LIMIT, {8'($urandom), o_l});
			write_reg(REG_INTEGRAL_LIMIT, i_l);
			write_reg(REG_DEADZONE_OFFSET, {8'($urandom), d_z});

			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
				default: begin send_idle_pct = 14; recv_stall_pct = 14; end
			endcase

			for (int n = 0; n < WORDS_PER_PHASE; n++) begin
				// long output hold-off so the pipe backs up into the input
				if (ph == 0 && n == 20)
					hold_asked++;
				// pause the input until the loop has drained
				if (ph == 4 && n == 60)
					settle();
				t = int'($urandom_range(0, 65535)) - 32768;
				if ($urandom_range(0, 3) == 0) begin
					m = int'($urandom_range(0, 65535)) - 32768;
				end else begin
					// measured rate tracking the target
					m = t + int'($urandom_range(0, 600)) - 300;
					if (m > 32767)
						m = 32767;
					else if (m < -32768)
						m = -32768;
				end
				send_word(16'(t), 16'(m), 1'b0, '0);
			end
		end

		settle();
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Watchdog
	initial begin
		#(TIMEOUT_NS);
		$display("simulation failed");
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/pldc_pkg.sv
hdl/pldc_cfg.sv
hdl/pldc_state.sv
hdl/pldc_law.sv
hdl/pid_loop_deadzone_compensated.sv
verif/pid_loop_deadzone_compensated_tb.sv
